// File: hdl/caf_pkg.sv
`default_nettype none

package caf_pkg;

	localparam int OpWidth   = 5;
	localparam int WordWidth = 16;
	localparam int ByteWidth = 8;
	localparam int BitWidth  = 3;
	localparam int FlagWidth = 4;

	typedef logic [OpWidth-1:0]   op_t;
	typedef logic [WordWidth-1:0] word_t;
	typedef logic [ByteWidth-1:0] byte_t;
	typedef logic [FlagWidth-1:0] flags_t;

	localparam op_t OP_ADD   = 5'd0;
	localparam op_t OP_ADC   = 5'd1;
	localparam op_t OP_SUB   = 5'd2;
	localparam op_t OP_SBC   = 5'd3;
	localparam op_t OP_AND   = 5'd4;
	localparam op_t OP_XOR   = 5'd5;
	localparam op_t OP_OR    = 5'd6;
	localparam op_t OP_CP    = 5'd7;
	localparam op_t OP_INC   = 5'd8;
	localparam op_t OP_DEC   = 5'd9;
	localparam op_t OP_DAA   = 5'd10;
	localparam op_t OP_CPL   = 5'd11;
	localparam op_t OP_SCF   = 5'd12;
	localparam op_t OP_CCF   = 5'd13;
	localparam op_t OP_RLCA  = 5'd14;
	localparam op_t OP_RRCA  = 5'd15;
	localparam op_t OP_RLA   = 5'd16;
	localparam op_t OP_RRA   = 5'd17;
	localparam op_t OP_RLC   = 5'd18;
	localparam op_t OP_RRC   = 5'd19;
	localparam op_t OP_RL    = 5'd20;
	localparam op_t OP_RR    = 5'd21;
	localparam op_t OP_SLA   = 5'd22;
	localparam op_t OP_SRA   = 5'd23;
	localparam op_t OP_SWAP  = 5'd24;
	localparam op_t OP_SRL   = 5'd25;
	localparam op_t OP_BIT   = 5'd26;
	localparam op_t OP_RES   = 5'd27;
	localparam op_t OP_SET   = 5'd28;
	localparam op_t OP_ADD16 = 5'd29;
	localparam op_t OP_ADDSP = 5'd30;
	localparam op_t OP_NOP   = 5'd31;

	localparam int FlagZ = 3;
	localparam int FlagN = 2;
	localparam int FlagH = 1;
	localparam int FlagC = 0;

endpackage

`default_nettype wire

// File: hdl/cpu_alu_with_flags.sv
// Eight-bit CPU arithmetic unit with Z, N, H and C flags, plus the 16-bit HL and stack-pointer
// adds. An operation is taken on every clock edge at which start is high; busy never rises, so
// one transfer per cycle is sustained. The operands go into an input register, the arithmetic
// runs in a single combinational pass, and the outcome lands in a result register: done rises
// at the clock edge after the one that takes the operation and stays high for exactly one
// cycle, with result_value, flags_out and writes_result valid alongside it. The receiver cannot
// stall the unit and must take each result in the cycle in which done is high.

`default_nettype none

module cpu_alu_with_flags
	import caf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [OpWidth-1:0]   operation,
	input  wire logic [WordWidth-1:0] first_operand,
	input  wire logic [WordWidth-1:0] second_operand,
	input  wire logic [BitWidth-1:0]  bit_number,
	input  wire logic [FlagWidth-1:0] flags_in,
	output logic                      done,
	output logic [WordWidth-1:0]      result_value,
	output logic [FlagWidth-1:0]      flags_out,
	output logic                      writes_result
);

	logic                 valid_s1;
	op_t                  op_s1;
	word_t                x_s1;
	word_t                y_s1;
	logic [BitWidth-1:0]  bn_s1;
	flags_t               f_s1;

	logic                 valid_s2;
	word_t                result_s2;
	flags_t               flags_s2;
	logic                 wr_s2;

	word_t                res_c;
	flags_t               flg_c;
	logic                 wr_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_s1 <= operation;
			x_s1  <= first_operand;
			y_s1  <= second_operand;
			bn_s1 <= bit_number;
			f_s1  <= flags_in;
		end
		if (valid_s1) begin
			result_s2 <= res_c;
			flags_s2  <= flg_c;
			wr_s2     <= wr_c;
		end
	end

	always_comb begin
		byte_t        a;
		byte_t        b;
		byte_t        r;
		logic         cin;
		logic         t;
		logic [8:0]   sum9;
		logic [4:0]   nib5;
		logic [8:0]   dif9;
		logic [4:0]   nibd5;
		byte_t        corr;
		logic         dc;
		logic [16:0]  sum17;
		logic [12:0]  sum13;
		word_t        ext;
		byte_t        mask;

		a     = x_s1[ByteWidth-1:0];
		b     = y_s1[ByteWidth-1:0];
		cin   = f_s1[FlagC];
		t     = ((op_s1 == OP_ADC) || (op_s1 == OP_SBC)) ? cin : 1'b0;
		sum9  = {1'b0, a} + {1'b0, b} + {8'd0, t};
		nib5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
		dif9  = {1'b0, a} - {1'b0, b} - {8'd0, t};
		nibd5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
		mask  = byte_t'(8'd1 << bn_s1);

		corr = 8'h00;
		dc   = 1'b0;
		if (f_s1[FlagH] || (!f_s1[FlagN] && (a[3:0] > 4'd9))) begin
			corr = 8'h06;
		end
		if (cin || (!f_s1[FlagN] && (a > 8'h99))) begin
			corr = corr | 8'h60;
			dc   = 1'b1;
		end

		sum17 = {1'b0, x_s1} + {1'b0, y_s1};
		sum13 = {1'b0, x_s1[11:0]} + {1'b0, y_s1[11:0]};
		ext   = {{ByteWidth{b[7]}}, b};

		r     = a;
		res_c = word_t'(a);
		flg_c = f_s1;
		wr_c  = 1'b1;

		case (op_s1) inside
			OP_ADD, OP_ADC: begin
				r     = sum9[7:0];
				flg_c = {r == 8'h00, 1'b0, nib5[4], sum9[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				r     = dif9[7:0];
				flg_c = {r == 8'h00, 1'b1, nibd5[4], dif9[8]};
				if (op_s1 == OP_CP) begin
					r    = a;
					wr_c = 1'b0;
				end
			end
			OP_AND: begin
				r     = a & b;
				flg_c = {r == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			OP_XOR: begin
				r     = a ^ b;
				flg_c = {r == 8'h00, 3'b000};
			end
			OP_OR: begin
				r     = a | b;
				flg_c = {r == 8'h00, 3'b000};
			end
			OP_INC: begin
				r     = a + 8'd1;
				flg_c = {r == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
			end
			OP_DEC: begin
				r     = a - 8'd1;
				flg_c = {r == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
			end
			OP_DAA: begin
				r     = f_s1[FlagN] ? (a - corr) : (a + corr);
				flg_c = {r == 8'h00, f_s1[FlagN], 1'b0, dc};
			end
			OP_CPL: begin
				r     = ~a;
				flg_c = {f_s1[FlagZ], 1'b1, 1'b1, cin};
			end
			OP_SCF: flg_c = {f_s1[FlagZ], 3'b001};
			OP_CCF: flg_c = {f_s1[FlagZ], 2'b00, ~cin};
			OP_RLCA: begin
				r     = {a[6:0], a[7]};
				flg_c = {3'b000, a[7]};
			end
			OP_RRCA: begin
				r     = {a[0], a[7:1]};
				flg_c = {3'b000, a[0]};
			end
			OP_RLA: begin
				r     = {a[6:0], cin};
				flg_c = {3'b000, a[7]};
			end
			OP_RRA: begin
				r     = {cin, a[7:1]};
				flg_c = {3'b000, a[0]};
			end
			OP_RLC: begin
				r     = {a[6:0], a[7]};
				flg_c = {r == 8'h00, 2'b00, a[7]};
			end
			OP_RRC: begin
				r     = {a[0], a[7:1]};
				flg_c = {r == 8'h00, 2'b00, a[0]};
			end
			OP_RL: begin
				r     = {a[6:0], cin};
				flg_c = {r == 8'h00, 2'b00, a[7]};
			end
			OP_RR: begin
				r     = {cin, a[7:1]};
				flg_c = {r == 8'h00, 2'b00, a[0]};
			end
			OP_SLA: begin
				r     = {a[6:0], 1'b0};
				flg_c = {r == 8'h00, 2'b00, a[7]};
			end
			OP_SRA: begin
				r     = {a[7], a[7:1]};
				flg_c = {r == 8'h00, 2'b00, a[0]};
			end
			OP_SWAP: begin
				r     = {a[3:0], a[7:4]};
				flg_c = {r == 8'h00, 3'b000};
			end
			OP_SRL: begin
				r     = {1'b0, a[7:1]};
				flg_c = {r == 8'h00, 2'b00, a[0]};
			end
			OP_BIT: begin
				flg_c = {(a & mask) == 8'h00, 1'b0, 1'b1, cin};
				wr_c  = 1'b0;
			end
			OP_RES: r = a & ~mask;
			OP_SET: r = a | mask;
			default: ;
		endcase

		res_c = word_t'(r);

		case (op_s1)
			OP_ADD16: begin
				res_c = sum17[WordWidth-1:0];
				flg_c = {f_s1[FlagZ], 1'b0, sum13[12], sum17[16]};
			end
			OP_ADDSP: begin
				res_c = x_s1 + ext;
				flg_c = {2'b00,
					({1'b0, x_s1[3:0]} + {1'b0, b[3:0]}) > 5'h0F,
					({1'b0, x_s1[7:0]} + {1'b0, b}) > 9'h0FF};
			end
			OP_NOP: begin
				res_c = x_s1;
				wr_c  = 1'b0;
			end
			default: ;
		endcase
	end

	assign done          = valid_s2;
	assign result_value  = result_s2;
	assign flags_out     = flags_s2;
	assign writes_result = wr_s2;

endmodule

`default_nettype wire
